/* rtl/sv39ptb_pkg.sv */
`default_nettype none

package sv39ptb_pkg;

  localparam int LEVELS     = 3;
  localparam int INDEX_BITS = 9;
  localparam int VA_WIDTH   = 39;
  localparam int PAGE_SHIFT = 12;
  localparam int MAX_PAGES  = 64;

  localparam int PA_W         = 56;
  localparam int FLAGS_W      = 10;
  localparam int PAGE_COUNT_W = 7;
  localparam int PTE_W        = 64;
  localparam int PTE_SHIFT    = 10;
  localparam int PPN_W        = PA_W - PAGE_SHIFT;

  localparam int ENTRIES   = 1 << INDEX_BITS;
  localparam int PAGE_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NFP_W     = $clog2(MAX_PAGES + 1);
  localparam int CNT_W     = (NFP_W > PAGE_COUNT_W) ? NFP_W : PAGE_COUNT_W;
  localparam int ADDR_W    = PAGE_W + INDEX_BITS;
  localparam int MEM_DEPTH = MAX_PAGES * ENTRIES;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam int FIRST_FREE_PAGE  = 2;
  localparam int PAGE_COUNT_RESET = 64;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PAGE  = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]          op;
    logic [VA_WIDTH-1:0] vaddr;
    logic [PA_W-1:0]     paddr;
    logic [FLAGS_W-1:0]  flags;
  } req_t;

  typedef struct packed {
    logic [PA_W-1:0] result_addr;
    logic [1:0]      status;
  } rsp_t;

  function automatic int lvl_shift(int l);
    int s;
    s = VA_WIDTH - (l + 1) * INDEX_BITS;
    return (s < 0) ? 0 : s;
  endfunction

  function automatic logic [INDEX_BITS-1:0] level_index(logic [VA_WIDTH-1:0] va,
                                                        logic [LVL_W-1:0] lv);
    logic [INDEX_BITS-1:0] r;
    r = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lv == LVL_W'(l)) begin
        r = INDEX_BITS'(va >> lvl_shift(l));
      end
    end
    return r;
  endfunction

  function automatic logic [PTE_W-1:0] make_pte(logic [PPN_W-1:0] ppn,
                                                logic [FLAGS_W-1:0] fl);
    return PTE_W'({ppn, fl[FLAGS_W-1:1], 1'b1});
  endfunction

endpackage

`default_nettype wire

/* rtl/sv39_page_table_builder.sv */
`default_nettype none

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_t  {op, vaddr, paddr, flags}
// rsp       out        rsp_valid/rsp_stall   rsp_t  {result_addr, status}
// apb       in         psel/penable/pwrite   base_addr @ 0x0, page_count @ 0x8
//
// A request walks the table in a read state and an evaluate state per non-leaf level,
// then writes the leaf and loads the result; a failing walk ends early.
// After reset a sweep zeroes all MAX_PAGES*512 (32768) table entries, one entry a
// cycle; req_stall stays high meanwhile, configuration writes are taken.
// A result waiting under rsp_stall does not block the next request; that request
// holds in its final state (S_FIN) until the output register frees.
module sv39_page_table_builder
  import sv39ptb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EV, S_LEAF, S_FIN} state_t;

  state_t                  state;
  logic [ADDR_W-1:0]       clr_addr;
  logic [NFP_W-1:0]        nfp;
  logic [PA_W-1:0]         base_addr;
  logic [PAGE_COUNT_W-1:0] page_count;

  logic [VA_WIDTH-1:0]     va;
  logic [FLAGS_W-1:0]      flags;
  logic [PPN_W-1:0]        leaf_ppn;
  logic                    create;
  logic [PAGE_W-1:0]       page;
  logic [LVL_W-1:0]        level;
  logic [PA_W-1:0]         res_addr;
  logic [1:0]              res_status;

  logic [PTE_W-1:0]        mem [MEM_DEPTH];
  logic [PTE_W-1:0]        rdata;
  logic                    mem_we;
  logic [ADDR_W-1:0]       waddr;
  logic [PTE_W-1:0]        wdata;

  logic [ADDR_W-1:0]       rd_addr;
  logic [PPN_W-1:0]        base_ppn;
  logic [PPN_W-1:0]        np_ppn;
  logic [CNT_W-1:0]        usable;
  logic                    has_free;
  logic                    ent_valid;
  logic [PPN_W-1:0]        rel;
  logic                    rel_bad;

  assign pready    = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign prdata    = (paddr[3] == REG_COUNT) ? 64'(page_count) : 64'(base_addr);

  always_comb begin
    rd_addr   = {page, level_index(va, level)};
    base_ppn  = base_addr[PA_W-1:PAGE_SHIFT];
    np_ppn    = base_ppn + PPN_W'(nfp);
    usable    = (CNT_W'(page_count) < CNT_W'(MAX_PAGES)) ? CNT_W'(page_count)
                                                           : CNT_W'(MAX_PAGES);
    has_free  = CNT_W'(nfp) < usable;
    ent_valid = rdata[0];
    rel       = rdata[PTE_SHIFT +: PPN_W] - base_ppn;
    rel_bad   = rel >= PPN_W'(MAX_PAGES);
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = rd_addr;
    wdata  = '0;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
      end
      S_EV: begin
        mem_we = !ent_valid && create && has_free;
        wdata  = make_pte(np_ppn, '0);
      end
      S_LEAF: begin
        mem_we = 1'b1;
        wdata  = create ? make_pte(leaf_ppn, flags) : '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr  <= '0;
      page_count <= PAGE_COUNT_W'(PAGE_COUNT_RESET);
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_COUNT) begin
        page_count <= pwdata[PAGE_COUNT_W-1:0];
      end else begin
        base_addr <= pwdata[PA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      nfp       <= NFP_W'(FIRST_FREE_PAGE);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            va     <= req.vaddr;
            flags  <= req.flags;
            page   <= '0;
            level  <= '0;
            create <= (req.op != OP_CLEAR);
            unique case (req.op)
              OP_MAP: begin
                leaf_ppn   <= req.paddr[PA_W-1:PAGE_SHIFT];
                res_addr   <= PA_W'(req.vaddr);
                res_status <= ST_OK;
                state      <= S_RD;
              end
              OP_ALLOC: begin
                if (has_free) begin
                  leaf_ppn   <= np_ppn;
                  res_addr   <= {np_ppn, {PAGE_SHIFT{1'b0}}};
                  res_status <= ST_OK;
                  nfp        <= nfp + 1'b1;
                  state      <= S_RD;
                end else begin
                  res_addr   <= '0;
                  res_status <= ST_NO_PAGE;
                  state      <= S_FIN;
                end
              end
              OP_CLEAR: begin
                res_addr   <= '0;
                res_status <= ST_OK;
                state      <= S_RD;
              end
              default: begin
                res_addr   <= '0;
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (!ent_valid && !create) begin
            res_addr   <= '0;
            res_status <= ST_UNMAPPED;
            state      <= S_FIN;
          end else if (!ent_valid && !has_free) begin
            res_addr   <= '0;
            res_status <= ST_NO_PAGE;
            state      <= S_FIN;
          end else if (ent_valid && rel_bad) begin
            res_addr   <= '0;
            res_status <= create ? ST_NO_PAGE : ST_UNMAPPED;
            state      <= S_FIN;
          end else begin
            if (ent_valid) begin
              page <= rel[PAGE_W-1:0];
            end else begin
              page <= nfp[PAGE_W-1:0];
              nfp  <= nfp + 1'b1;
            end
            level <= level + 1'b1;
            state <= (level == LVL_W'(LEVELS - 2)) ? S_LEAF : S_RD;
          end
        end
        S_LEAF: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.result_addr <= res_addr;
            rsp.status      <= res_status;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_nfp_bound: assert property (@(posedge clk) disable iff (rst)
    (nfp >= NFP_W'(FIRST_FREE_PAGE)) && (CNT_W'(nfp) <= CNT_W'(MAX_PAGES)))
    else $error("free page pointer out of range");

  a_nfp_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (nfp != $past(nfp))) |-> (nfp == NFP_W'($past(nfp) + 1'b1)))
    else $error("free page pointer moved by other than one");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.result_addr == '0))
    else $error("failed transfer carries nonzero address");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside final state");

endmodule

`default_nettype wire
